// ===== src/set_assoc_cache_random_replace_top_macros.svh =====
// Assertion helpers for the cache block.
`ifndef SET_ASSOC_CACHE_RANDOM_REPLACE_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_RANDOM_REPLACE_TOP_MACROS_SVH
`define SAC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SAC_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== src/sac_pkg.sv =====
package sac_pkg;
  localparam int MEM_ADDR_BITS = 20;
  localparam int NUM_WAYS = 8;
  localparam int NUM_SETS = 128;
  localparam int LINE_BYTES = 64;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int unsigned LFSR_SEED = 16'hACE1;
  localparam int unsigned LFSR_TAPS = 16'hB400;

  typedef struct packed {
    logic        op;
    logic [31:0] addr;
    logic [2:0]  len;
    logic [31:0] wdata;
  } req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        h1;
    logic        h2;
    logic        crossed;
  } rsp_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    lfsr_step = v[0] ? ((v >> 1) ^ LFSR_TAPS[15:0]) : (v >> 1);
  endfunction
endpackage

// ===== src/sac_front.sv =====
module sac_front #(
  parameter int QDEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic operation,
  input  logic [19:0] address,
  input  logic [2:0] length,
  input  logic [31:0] write_data,
  output logic q_valid,
  input  logic q_take,
  output sac_pkg::req_t q_req
);
  import sac_pkg::*;
  localparam int CB = $clog2(QDEPTH+1);
  localparam int PB = $clog2(QDEPTH);
  req_t q [QDEPTH];
  logic [CB-1:0] cnt;
  logic [PB-1:0] rp, wp;
  logic [2:0] len_n;
  logic [31:0] a_w;
  req_t r_in;
  logic do_push, do_pop;

  always_comb begin
    len_n = (length == 3'd0) ? 3'd1 : ((length > 3'd4) ? 3'd4 : length);
    a_w = 32'(address) & 32'((33'(1) << MEM_ADDR_BITS) - 33'(1));
    r_in = '{op: operation, addr: a_w, len: len_n, wdata: write_data};
  end

  assign full = (cnt == CB'(QDEPTH));
  assign q_valid = (cnt != '0);
  assign q_req = q[rp];
  assign do_push = push && !full;
  assign do_pop = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) q[wp] <= r_in;
    if (rst) begin
      cnt <= '0; rp <= '0; wp <= '0;
    end else begin
      if (do_push) wp <= (wp == PB'(QDEPTH-1)) ? '0 : wp + 1'b1;
      if (do_pop) rp <= (rp == PB'(QDEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
    end
  end
endmodule

// ===== src/sac_back.sv =====
module sac_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_take,
  input  sac_pkg::req_t q_req,
  output logic o_valid,
  input  logic o_take,
  output sac_pkg::rsp_t o_rsp
);
  import sac_pkg::*;
  localparam int OB = $clog2(LINE_BYTES);
  localparam int WB = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int SB = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SBR = $clog2(NUM_SETS);
  localparam int TB = (MEM_ADDR_BITS - OB - SBR > 0) ? MEM_ADDR_BITS - OB - SBR : 1;
  localparam int NL = NUM_SETS * NUM_WAYS;
  localparam int LIB = $clog2(NL);
  localparam int LB = LIB + OB;
  localparam int MSZ = 1 << MEM_ADDR_BITS;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001, S_IDLE = 9'b000000010, S_TAGRD = 9'b000000100,
    S_LOOK = 9'b000001000, S_FILL = 9'b000010000, S_BRD = 9'b000100000,
    S_BYTE = 9'b001000000, S_NEXT = 9'b010000000, S_DONE = 9'b100000000
  } st_t;
  st_t st;

  logic [7:0] mem [MSZ];
  logic [7:0] lb [NL*LINE_BYTES];
  logic [TB-1:0] tagm [NL];
  logic [NUM_WAYS-1:0] vmem [NUM_SETS];
  logic [15:0] lfsr, lfsr_nv;

  req_t r;
  logic part;
  logic [31:0] pa;
  logic [2:0] n, bi, n1;
  logic [31:0] wd, acc;
  logic [2:0] sh;
  logic h1, h2, hit;
  logic [WB-1:0] way, wcnt, vfree;
  logic found, way_hit;
  logic [OB:0] fcnt;
  logic [7:0] mrd, lrd;
  logic [TB-1:0] trd;
  logic [NUM_WAYS-1:0] vrd;
  logic pend_fill;
  rsp_t rsp;
  logic ov;
  logic [MEM_ADDR_BITS-1:0] clr;

  logic [SB-1:0] set_a;
  logic [TB-1:0] tag_a;
  logic [OB-1:0] off_a;
  logic [LIB-1:0] lidx;
  logic [31:0] amask;

  assign amask = 32'((33'(1) << MEM_ADDR_BITS) - 33'(1));
  assign off_a = pa[OB-1:0];
  assign set_a = (NUM_SETS > 1) ? SB'(pa >> OB) : '0;
  assign tag_a = TB'(pa >> (OB + SBR));
  assign lidx = LIB'(set_a * NUM_WAYS + way);
  assign q_take = (st == S_IDLE) && q_valid;
  assign o_valid = ov;
  assign o_rsp = rsp;
  assign way_hit = vrd[wcnt] && (trd == tag_a);
  assign lfsr_nv = lfsr_step(lfsr);

  // lowest-numbered free way of the set
  always_comb begin
    found = 1'b0;
    vfree = '0;
    for (int w = NUM_WAYS-1; w >= 0; w--)
      if (!vrd[w]) begin
        found = 1'b1;
        vfree = WB'(w);
      end
  end

  // per-way tag compare is sequenced through the tag store one way at a time
  always_ff @(posedge clk) begin
    trd <= tagm[LIB'(set_a * NUM_WAYS + wcnt)];
    vrd <= vmem[set_a];
    mrd <= mem[MEM_ADDR_BITS'((pa & ~32'(LINE_BYTES-1)) + 32'(fcnt))];
    lrd <= lb[LB'({lidx, off_a + OB'(bi)})];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLEAR; clr <= '0; lfsr <= LFSR_SEED[15:0]; ov <= 1'b0;
    end else begin
      if (st == S_DONE && (!ov || o_take)) ov <= 1'b1;
      else if (o_take && ov) ov <= 1'b0;
      case (st)
        // zero backing memory and valid bits, one entry a cycle
        S_CLEAR: begin
          mem[clr] <= 8'd0;
          if (clr < MEM_ADDR_BITS'(NUM_SETS)) vmem[SB'(clr)] <= '0;
          if (clr == MEM_ADDR_BITS'(MSZ-1)) st <= S_IDLE;
          clr <= clr + 1'b1;
        end
        S_IDLE: if (q_take) begin
          r <= q_req; part <= 1'b0; pa <= q_req.addr; acc <= '0; sh <= '0;
          n1 <= ((LINE_BYTES - int'(q_req.addr[OB-1:0])) < int'(q_req.len)) ?
                3'(LINE_BYTES - int'(q_req.addr[OB-1:0])) : q_req.len;
          n <= ((LINE_BYTES - int'(q_req.addr[OB-1:0])) < int'(q_req.len)) ?
               3'(LINE_BYTES - int'(q_req.addr[OB-1:0])) : q_req.len;
          wd <= q_req.wdata; h1 <= 1'b0; h2 <= 1'b0;
          wcnt <= '0; hit <= 1'b0; st <= S_TAGRD;
        end
        S_TAGRD: st <= S_LOOK;
        S_LOOK: begin
          if (way_hit && !hit) begin
            hit <= 1'b1; way <= wcnt;
          end
          if (wcnt == WB'(NUM_WAYS-1)) begin
            bi <= '0;
            if (!way_hit && !hit && r.op == OP_READ) begin
              pend_fill <= 1'b1; fcnt <= '0; st <= S_FILL;
              if (found) way <= vfree;
              else begin
                lfsr <= lfsr_nv; way <= WB'(lfsr_nv % 16'(NUM_WAYS));
              end
            end else st <= S_BRD;
          end else begin
            wcnt <= wcnt + 1'b1; st <= S_TAGRD;
          end
        end
        S_FILL: begin
          // first cycle only reads; then one byte written per cycle
          pend_fill <= 1'b0;
          if (!pend_fill) lb[LB'({lidx, OB'(fcnt - 1'b1)})] <= mrd;
          if (fcnt == (OB+1)'(LINE_BYTES)) begin
            vmem[set_a] <= vrd | (NUM_WAYS'(1) << way);
            tagm[lidx] <= tag_a; st <= S_BRD;
          end else fcnt <= fcnt + 1'b1;
        end
        S_BRD: begin
          if (r.op == OP_WRITE) begin
            if (hit) lb[LB'({lidx, off_a + OB'(bi)})] <= wd[7:0];
            mem[MEM_ADDR_BITS'(pa + 32'(bi))] <= wd[7:0];
            wd <= wd >> 8;
            if (bi + 1'b1 == n) st <= S_NEXT; else bi <= bi + 1'b1;
          end else st <= S_BYTE;
        end
        S_BYTE: begin
          acc <= acc | (32'(lrd) << {sh, 3'b000});
          sh <= sh + 1'b1;
          if (bi + 1'b1 == n) st <= S_NEXT;
          else begin bi <= bi + 1'b1; st <= S_BRD; end
        end
        S_NEXT: begin
          if (!part) h1 <= hit; else h2 <= hit;
          if (!part && n1 < r.len) begin
            part <= 1'b1; pa <= (r.addr + 32'(n1)) & amask; n <= r.len - n1;
            wcnt <= '0; hit <= 1'b0; st <= S_TAGRD;
          end else st <= S_DONE;
        end
        S_DONE: if (!ov || o_take) begin
          rsp <= '{rdata: (r.op == OP_WRITE) ? 32'd0 : acc, h1: h1, h2: h2,
                   crossed: part};
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/set_assoc_cache_random_replace_top.sv =====
// Set-associative cache, 8 ways x 128 sets x 64-byte lines, write-through,
// random replacement, backing memory inside the block.
// Requests: push/full queue; operation, address, length (1..4), write_data.
// Results: empty/pop output register; read_data, first_hit, second_hit, crossed_line.
// A two-entry request queue decouples the front from the sequencer at back.
// After reset the sequencer zeroes backing memory and the valid bits; up to
// two requests queue up meanwhile.
// Per line part: a tag search through every way (S_TAGRD then S_LOOK for
// each), then S_BRD and S_BYTE per byte on reads or S_BRD per byte on
// writes, then S_NEXT; a read miss first adds a line refill in S_FILL.
// S_IDLE takes the request and S_DONE posts it.
// One request at a time: the next is taken from the queue only after the
// last one is posted.
// When pop stays low the result is held; the sequencer finishes the next
// request and waits, and push keeps filling the queue until full.
`include "set_assoc_cache_random_replace_top_macros.svh"
module set_assoc_cache_random_replace_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic operation,
  input  logic [19:0] address,
  input  logic [2:0] length,
  input  logic [31:0] write_data,
  output logic empty,
  input  logic pop,
  output logic [31:0] read_data,
  output logic first_hit,
  output logic second_hit,
  output logic crossed_line
);
  import sac_pkg::*;
  logic q_valid, q_take, o_valid;
  req_t q_req;
  rsp_t o_rsp;

  sac_front #(.QDEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst, .push, .full, .operation, .address, .length, .write_data,
    .q_valid, .q_take, .q_req);

  sac_back u_back (
    .clk, .rst, .q_valid, .q_take, .q_req, .o_valid, .o_take(pop), .o_rsp);

  assign empty = !o_valid;
  assign read_data = o_rsp.rdata;
  assign first_hit = o_rsp.h1;
  assign second_hit = o_rsp.h2;
  assign crossed_line = o_rsp.crossed;

  `SAC_ASSERT(a_hold, clk, rst, (!empty && !pop) |=> !empty, "result dropped")
  `SAC_ASSERT(a_h2, clk, rst, (!empty && !crossed_line) |-> !second_hit, "h2 w/o cross")
  `SAC_ASSERT_RST(a_rst, clk, rst |=> empty, "result after reset")
endmodule

// ===== tb/set_assoc_cache_random_replace_checker.sv =====
`timescale 1ns / 1ps
module set_assoc_cache_random_replace_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        operation,
  input  logic [19:0] address,
  input  logic [2:0]  length,
  input  logic [31:0] write_data,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] read_data,
  input  logic        first_hit,
  input  logic        second_hit,
  input  logic        crossed_line,
  output int          errors,
  output int          pending
);
  import sac_pkg::*;

  localparam int WAYS = 8;
  localparam int LBYTES = 64;

  // shadow of the cache and its backing store
  bit        line_ok [0:1023];
  bit [6:0]  line_tg [0:1023];
  bit [7:0]  line_data [0:65535];
  bit [7:0]  mem_bytes [0:1048575];
  bit [15:0] victim_lfsr;

  rsp_t expected_rsp[$];

  assign pending = expected_rsp.size();

  initial errors = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void access_line(input bit [19:0] a, input int n, input bit wr,
                                      input bit [31:0] wd, output bit hit,
                                      output bit [31:0] res);
    int off;
    int set_idx;
    bit [6:0] tg;
    int idx;
    int l;
    bit [19:0] base;
    off = int'(a[5:0]);
    set_idx = int'(a[12:6]);
    tg = a[19:13];
    hit = 0;
    idx = -1;
    res = 0;
    for (int w = 0; w < WAYS; w++) begin
      l = set_idx * WAYS + w;
      if (line_ok[l] && line_tg[l] == tg) begin
        hit = 1;
        idx = l;
        if (wr)
          for (int i = 0; i < n; i++) line_data[l * LBYTES + off + i] = wd[8 * i +: 8];
      end
    end
    if (wr) begin
      for (int i = 0; i < n; i++) mem_bytes[20'(a + i)] = wd[8 * i +: 8];
      return;
    end
    if (!hit) begin
      idx = -1;
      for (int w = 0; w < WAYS; w++)
        if (idx < 0 && !line_ok[set_idx * WAYS + w]) idx = set_idx * WAYS + w;
      if (idx < 0) begin
        victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_TAPS[15:0])
                                     : (victim_lfsr >> 1);
        idx = set_idx * WAYS + int'(victim_lfsr[2:0]);
      end
      base = {a[19:6], 6'b0};
      for (int i = 0; i < LBYTES; i++) line_data[idx * LBYTES + i] = mem_bytes[20'(base + i)];
      line_ok[idx] = 1;
      line_tg[idx] = tg;
    end
    for (int i = 0; i < n; i++) res |= 32'(line_data[idx * LBYTES + off + i]) << (8 * i);
  endfunction

  function automatic rsp_t predict_access(input bit wr, input bit [19:0] a,
                                          input bit [2:0] len_in, input bit [31:0] wd);
    rsp_t r;
    int len;
    int off;
    int n1;
    bit [31:0] d1;
    bit [31:0] d2;
    bit h1;
    bit h2;
    len = (len_in == 0) ? 1 : (len_in > 4) ? 4 : int'(len_in);
    off = int'(a[5:0]);
    n1 = (LBYTES - off < len) ? LBYTES - off : len;
    h2 = 0;
    d2 = 0;
    access_line(a, n1, wr, wd, h1, d1);
    r.crossed = n1 < len;
    if (n1 < len) access_line(20'(a + n1), len - n1, wr, wd >> (8 * n1), h2, d2);
    r.rdata = wr ? 32'h0 : (d1 | (d2 << (8 * n1)));
    r.h1 = h1;
    r.h2 = h2;
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      foreach (line_ok[i]) line_ok[i] = 0;
      victim_lfsr = LFSR_SEED[15:0];
      expected_rsp.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected result", read_data, 32'h0);
        end else begin
          want = expected_rsp.pop_front();
          if (read_data !== want.rdata) report("read_data", read_data, want.rdata);
          if (first_hit !== want.h1)
            report("first_hit", 32'(first_hit), 32'(want.h1));
          if (second_hit !== want.h2)
            report("second_hit", 32'(second_hit), 32'(want.h2));
          if (crossed_line !== want.crossed)
            report("crossed_line", 32'(crossed_line), 32'(want.crossed));
        end
      end
      if (push && !full)
        expected_rsp.push_back(predict_access(operation == OP_WRITE, address, length,
                                              write_data));
    end
  end
endmodule

// ===== tb/set_assoc_cache_random_replace_top_tb.sv =====
`timescale 1ns / 1ps
module set_assoc_cache_random_replace_top_tb;
  import sac_pkg::*;
  localparam int RANDOM_ITEMS = 1930;
  localparam int QUIET_TAIL = 300;
  localparam int CYCLE_LIMIT = 8000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic        full;
  logic        operation = OP_READ;
  logic [19:0] address = 0;
  logic [2:0]  length = 1;
  logic [31:0] write_data = 0;
  logic        empty;
  logic        pop = 0;
  logic [31:0] read_data;
  logic        first_hit;
  logic        second_hit;
  logic        crossed_line;
  int          errors;
  int          pending;
  int          cycles = 0;
  bit          quiet = 0;
  int          pop_hold = 0;

  always #1 clk = ~clk;

  set_assoc_cache_random_replace_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .address(address), .length(length), .write_data(write_data), .empty(empty),
    .pop(pop), .read_data(read_data), .first_hit(first_hit), .second_hit(second_hit),
    .crossed_line(crossed_line)
  );

  set_assoc_cache_random_replace_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .address(address), .length(length), .write_data(write_data), .empty(empty),
    .pop(pop), .read_data(read_data), .first_hit(first_hit), .second_hit(second_hit),
    .crossed_line(crossed_line), .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result-side stalls in bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      pop <= !rst;
      pop_hold <= 0;
    end else if (pop_hold > 0) begin
      pop <= 0;
      pop_hold <= pop_hold - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      pop <= 0;
      pop_hold <= $urandom_range(0, 9);
    end else begin
      pop <= 1;
    end
  end

  // one request; push then stays high until the next call or the end, unless a random gap drops it
  task automatic send_request(input logic op, input logic [19:0] a, input logic [2:0] n,
                              input logic [31:0] wd);
    push <= 1;
    operation <= op;
    address <= a;
    length <= n;
    write_data <= wd;
    do @(posedge clk); while (full);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // mostly a few hot sets and a handful of tags so hits and replacement happen
  function automatic logic [19:0] pick_address();
    logic [6:0] tg;
    logic [6:0] set_idx;
    logic [5:0] off;
    if ($urandom_range(0, 9) == 0) return 20'($urandom);
    tg = 7'($urandom_range(0, 11));
    case ($urandom_range(0, 3))
      0: set_idx = 7'd0;
      1: set_idx = 7'd5;
      2: set_idx = 7'd6;
      default: set_idx = 7'd127;
    endcase
    off = $urandom_range(0, 1) ? 6'($urandom_range(60, 63)) : 6'($urandom);
    return {tg, set_idx, off};
  endfunction

  initial begin
    int waited;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed part
    send_request(OP_READ, 20'h00000, 3'd4, 32'h0);
    send_request(OP_WRITE, 20'h00000, 3'd4, 32'hDEADBEEF);
    send_request(OP_READ, 20'h00000, 3'd4, 32'h0);
    send_request(OP_READ, 20'h00001, 3'd0, 32'h0);
    send_request(OP_READ, 20'h00000, 3'd7, 32'h0);
    send_request(OP_WRITE, 20'h0003E, 3'd4, 32'hFFFFFFFF);
    send_request(OP_READ, 20'h0003E, 3'd4, 32'h0);
    send_request(OP_READ, 20'h0003D, 3'd4, 32'h0);
    send_request(OP_WRITE, 20'hFFFFE, 3'd4, 32'hA5C3_5A3C);
    send_request(OP_READ, 20'hFFFFF, 3'd4, 32'h0);
    send_request(OP_WRITE, 20'hFFFFF, 3'd5, 32'h1234_5678);
    send_request(OP_READ, 20'hFFFFC, 3'd6, 32'h0);
    // ten tags in one set forces the LFSR victim choice
    for (int t = 0; t < 10; t++) send_request(OP_READ, {7'(t), 7'd3, 6'd8}, 3'd2, 32'h0);
    send_request(OP_WRITE, {7'd9, 7'd3, 6'd8}, 3'd3, 32'h00C0FFEE);
    send_request(OP_READ, {7'd9, 7'd3, 6'd8}, 3'd3, 32'h0);

    // hold off until the block has drained
    push <= 0;
    while (pending != 0) @(posedge clk);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - QUIET_TAIL) quiet = 1;
      send_request($urandom_range(0, 9) < 4 ? OP_WRITE : OP_READ, pick_address(),
                   $urandom_range(0, 4) == 0 ? 3'($urandom) : 3'($urandom_range(1, 4)),
                   $urandom);
    end
    push <= 0;
    quiet = 1;

    while (pending != 0) @(posedge clk);
    waited = 0;
    while (waited < 400) begin
      @(posedge clk);
      waited++;
    end
    if (errors == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
